/* sv/bdr_pkg.sv */
// ----------------------------------------------------------------------------
// Buck duty regulator package
// Shared widths, register indexes, reset values, scaling constants and types.
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int WINDOW_SIZE     = 8;
  localparam int SLOT_W          = 3;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int MV_W      = 12;
  localparam int DUTY_W    = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = 13;
  localparam int DIFF_W    = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_TRIP    = 3'd4;

  localparam logic [MV_W-1:0]   SETPOINT_RST     = 12'd1363;
  localparam logic [MV_W-1:0]   TRIP_RST         = 12'd1454;
  localparam logic [DUTY_W-1:0] DUTY_FLOOR_RST   = 11'd75;
  localparam logic [DUTY_W-1:0] DUTY_CEILING_RST = 11'd400;
  localparam logic [DUTY_W-1:0] DUTY_TRIP_RST    = 11'd100;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 11'd1499;
  localparam logic [MV_W-1:0]   MV_MAX   = 12'd4095;

  // mV = mean * 805 / 1000 = ((mean * 161) >> 3) / 25
  localparam int              MV_SCALE_W   = 8;
  localparam logic [7:0]      MV_SCALE     = 8'd161;
  localparam int              MV_PRE_SHIFT = 3;
  localparam int              MV_DIV       = 25;
  localparam int              MV_DIV_LOG   = 5;

  // |e| / 80 = ((|e| >> 4) * 410) >> 11, exact for |e| < 4096
  localparam int         E_PRE_SHIFT = 4;
  localparam int         E_RCP_W     = 9;
  localparam logic [8:0] E_RECIP     = 9'd410;
  localparam int         E_SHIFT     = 11;

  // |d| / 20 = ((|d| >> 2) * 3277) >> 14, exact for |d| < 8192
  localparam int          D_PRE_SHIFT = 2;
  localparam int          D_RCP_W     = 12;
  localparam logic [11:0] D_RECIP     = 12'd3277;
  localparam int          D_SHIFT     = 14;

  typedef struct packed {
    logic [MV_W-1:0]   setpoint_mv;
    logic [MV_W-1:0]   trip_mv;
    logic [DUTY_W-1:0] duty_floor;
    logic [DUTY_W-1:0] duty_ceiling;
    logic [DUTY_W-1:0] duty_trip;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DUTY_W-1:0] duty;
    logic              below_setpoint;
    logic [MV_W-1:0]   measured_mv;
  } res_t;

endpackage

/* sv/bdr_trim.sv */
// ----------------------------------------------------------------------------
// Sample window and trimmed sum
// Ring of samples plus one shared compare unit that scans the window four
// times (two largest, two smallest) and leaves the sum of the middle four.
// ----------------------------------------------------------------------------
module bdr_trim #(
  parameter int SAMPLE_BITS = bdr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   store_en,
  input  logic [SAMPLE_BITS-1:0] store_sample,
  input  logic                   start,
  output logic                   done,
  output logic [SAMPLE_BITS+1:0] mid_sum
);
  import bdr_pkg::*;

  localparam int TOT_W = SAMPLE_BITS + SLOT_W;
  localparam logic [1:0] PH_MAX1 = 2'd0;
  localparam logic [1:0] PH_MAX2 = 2'd1;
  localparam logic [1:0] PH_MIN1 = 2'd2;
  localparam logic [1:0] PH_MIN2 = 2'd3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);

  logic [SAMPLE_BITS-1:0] win_r [WINDOW_SIZE];
  logic [SLOT_W-1:0]      slot_r;
  logic                   busy_r;
  logic                   done_r;
  logic [1:0]             phase_r;
  logic [SLOT_W-1:0]      idx_r;
  logic                   have_r;
  logic [SAMPLE_BITS-1:0] best_r;
  logic [SLOT_W-1:0]      bidx_r;
  logic [SLOT_W-1:0]      ex_max_r;
  logic [SLOT_W-1:0]      ex_min_r;
  logic [TOT_W-1:0]       total_r;

  logic [SAMPLE_BITS-1:0] cur;
  logic                   find_max;
  logic                   excl;
  logic [SAMPLE_BITS-1:0] cmp_a;
  logic [SAMPLE_BITS-1:0] cmp_b;
  logic                   better;
  logic                   take;
  logic [SAMPLE_BITS-1:0] best_nxt;
  logic [SLOT_W-1:0]      bidx_nxt;
  logic [TOT_W-1:0]       total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_r[i] <= '0;
      end
      slot_r <= '0;
    end else if (store_en) begin
      win_r[slot_r] <= store_sample;
      slot_r        <= slot_r + SLOT_W'(1);
    end
  end

  always_comb begin
    cur      = win_r[idx_r];
    find_max = (phase_r == PH_MAX1) || (phase_r == PH_MAX2);
    excl     = ((phase_r == PH_MAX2) && (idx_r == ex_max_r)) ||
               ((phase_r == PH_MIN2) && (idx_r == ex_min_r));
    cmp_a    = find_max ? cur : best_r;
    cmp_b    = find_max ? best_r : cur;
    better   = cmp_a > cmp_b;
    take     = !excl && (!have_r || better);
    best_nxt = take ? cur : best_r;
    bidx_nxt = take ? idx_r : bidx_r;
    total_nxt = (phase_r == PH_MAX1) ? total_r + TOT_W'(cur) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_MAX1;
      idx_r   <= '0;
      have_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= PH_MAX1;
        idx_r   <= '0;
        have_r  <= 1'b0;
      end else if (busy_r) begin
        idx_r <= idx_r + SLOT_W'(1);
        if (idx_r == LAST_SLOT) begin
          phase_r <= phase_r + 2'd1;
          have_r  <= 1'b0;
          if (phase_r == PH_MIN2) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          have_r <= have_r | take;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      total_r <= '0;
    end else if (busy_r) begin
      if (idx_r == LAST_SLOT) begin
        total_r <= total_nxt - TOT_W'(best_nxt);
        if (phase_r == PH_MAX1) begin
          ex_max_r <= bidx_nxt;
        end
        if (phase_r == PH_MIN1) begin
          ex_min_r <= bidx_nxt;
        end
      end else begin
        total_r <= total_nxt;
        best_r  <= best_nxt;
        bidx_r  <= bidx_nxt;
      end
    end
  end

  assign done    = done_r;
  assign mid_sum = total_r[SAMPLE_BITS+1:0];

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("trim done without a scan");
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> (idx_r == '0))
    else $error("scan index not parked at zero");
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("scan restarted while busy");
`endif

endmodule

/* sv/bdr_law.sv */
// ----------------------------------------------------------------------------
// Scaling and duty control law
// Sequencer that scales the trimmed sum to mV, forms the error terms and
// steps the duty, with each of its four multiplies in a state of its own.
// ----------------------------------------------------------------------------
module bdr_law #(
  parameter int SAMPLE_BITS = bdr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS+1:0] mid_sum,
  input  bdr_pkg::cfg_t          cfg,
  input  logic                   out_free,
  output bdr_pkg::res_t          res
);
  import bdr_pkg::*;

  localparam int SUM_W     = SAMPLE_BITS + 2;
  localparam int X_W       = SAMPLE_BITS + MV_SCALE_W;
  localparam int Y_W       = X_W - MV_PRE_SHIFT;
  localparam int RCP_SHIFT = Y_W + MV_DIV_LOG;
  localparam int RCP_W     = RCP_SHIFT - MV_DIV_LOG + 1;
  localparam longint RCP_VAL = ((longint'(1) << RCP_SHIFT) + MV_DIV - 1) / MV_DIV;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);
  localparam int P_W  = Y_W + RCP_W;
  localparam int QX_W = (SAMPLE_BITS > MV_W) ? SAMPLE_BITS : MV_W;
  localparam int E_HI_W = ERR_W - 1 - E_PRE_SHIFT;
  localparam int E_P_W  = E_HI_W + E_RCP_W;
  localparam int QE_W   = E_P_W - E_SHIFT;
  localparam int D_HI_W = DIFF_W - 1 - D_PRE_SHIFT;
  localparam int D_P_W  = D_HI_W + D_RCP_W;
  localparam int QD_W   = D_P_W - D_SHIFT;
  localparam int C_W    = 14;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_RECIP = 3'd2;
  localparam logic [2:0] ST_ERR   = 3'd3;
  localparam logic [2:0] ST_QE    = 3'd4;
  localparam logic [2:0] ST_QD    = 3'd5;
  localparam logic [2:0] ST_DUTY  = 3'd6;

  logic [2:0]               state_r;
  logic [DUTY_W-1:0]        duty_now_r;
  logic signed [ERR_W-1:0]  last_err_r;
  logic [SUM_W-1:0]         sum_r;
  logic [X_W-1:0]           x_r;
  logic [P_W-1:0]           p_r;
  logic [MV_W-1:0]          mv_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     below_r;
  logic                     trip_r;
  logic [QE_W-1:0]          qe_r;
  logic [QD_W-1:0]          qd_r;
  logic                     res_valid_r;
  logic [DUTY_W-1:0]        res_duty_r;
  logic                     res_below_r;
  logic [MV_W-1:0]          res_mv_r;

  logic [SAMPLE_BITS-1:0]   mean;
  logic [Y_W-1:0]           y;
  logic [SAMPLE_BITS-1:0]   q;
  logic [QX_W-1:0]          q_wide;
  logic [MV_W-1:0]          mv_sat;
  logic signed [ERR_W-1:0]  mv_s;
  logic signed [ERR_W-1:0]  sp_s;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [DIFF_W-1:0] err_ext;
  logic signed [DIFF_W-1:0] last_ext;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic                     below_nxt;
  logic [ERR_W-1:0]         e_mag;
  logic [E_P_W-1:0]         e_prod;
  logic [DIFF_W-1:0]        d_mag;
  logic [D_P_W-1:0]         d_prod;
  logic signed [C_W-1:0]    duty_s;
  logic signed [C_W-1:0]    qe_s;
  logic signed [C_W-1:0]    qd_s;
  logic signed [C_W-1:0]    c_raw;
  logic signed [C_W-1:0]    floor_s;
  logic signed [C_W-1:0]    ceil_s;
  logic signed [C_W-1:0]    trip_s;
  logic signed [C_W-1:0]    dmax_s;
  logic signed [C_W-1:0]    c_lim;
  logic signed [C_W-1:0]    c_sat;

  always_comb begin
    mean      = sum_r[SUM_W-1:2];
    y         = x_r[X_W-1:MV_PRE_SHIFT];
    q         = p_r[RCP_SHIFT +: SAMPLE_BITS];
    q_wide    = QX_W'(q);
    mv_sat    = (q_wide > QX_W'(MV_MAX)) ? MV_MAX : q_wide[MV_W-1:0];
    mv_s      = {1'b0, mv_sat};
    sp_s      = {1'b0, cfg.setpoint_mv};
    err_nxt   = mv_s - sp_s;
    err_ext   = DIFF_W'(err_nxt);
    last_ext  = DIFF_W'(last_err_r);
    diff_nxt  = err_ext - last_ext;
    below_nxt = mv_sat <= cfg.setpoint_mv;

    e_mag  = err_r[ERR_W-1] ? -err_r : err_r;
    e_prod = E_P_W'(e_mag[ERR_W-2:E_PRE_SHIFT]) * E_P_W'(E_RECIP);
    d_mag  = diff_r[DIFF_W-1] ? -diff_r : diff_r;
    d_prod = D_P_W'(d_mag[DIFF_W-2:D_PRE_SHIFT]) * D_P_W'(D_RECIP);

    duty_s  = {{(C_W-DUTY_W){1'b0}}, duty_now_r};
    qe_s    = err_r[ERR_W-1] ? -C_W'(qe_r) : C_W'(qe_r);
    qd_s    = diff_r[DIFF_W-1] ? -C_W'(qd_r) : C_W'(qd_r);
    c_raw   = duty_s - qe_s + (below_r ? -qd_s : qd_s);
    floor_s = {{(C_W-DUTY_W){1'b0}}, cfg.duty_floor};
    ceil_s  = {{(C_W-DUTY_W){1'b0}}, cfg.duty_ceiling};
    trip_s  = {{(C_W-DUTY_W){1'b0}}, cfg.duty_trip};
    dmax_s  = {{(C_W-DUTY_W){1'b0}}, DUTY_MAX};
    if (trip_r) begin
      c_lim = trip_s;
    end else if (!below_r) begin
      c_lim = (c_raw < floor_s) ? floor_s : c_raw;
    end else begin
      c_lim = (c_raw > ceil_s) ? ceil_s : c_raw;
    end
    if (c_lim < 0) begin
      c_sat = '0;
    end else if (c_lim > dmax_s) begin
      c_sat = dmax_s;
    end else begin
      c_sat = c_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      duty_now_r  <= '0;
      last_err_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: state_r <= ST_RECIP;
        ST_RECIP: state_r <= ST_ERR;
        ST_ERR:   state_r <= ST_QE;
        ST_QE:    state_r <= ST_QD;
        ST_QD:    state_r <= ST_DUTY;
        ST_DUTY: begin
          if (out_free) begin
            duty_now_r  <= c_sat[DUTY_W-1:0];
            last_err_r  <= err_r;
            res_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == ST_IDLE)) begin
      sum_r <= mid_sum;
    end
    if (state_r == ST_SCALE) begin
      x_r <= X_W'(mean) * X_W'(MV_SCALE);
    end
    if (state_r == ST_RECIP) begin
      p_r <= P_W'(y) * P_W'(RCP);
    end
    if (state_r == ST_ERR) begin
      mv_r    <= mv_sat;
      err_r   <= err_nxt;
      diff_r  <= diff_nxt;
      below_r <= below_nxt;
      trip_r  <= !below_nxt && (mv_sat > cfg.trip_mv);
    end
    if (state_r == ST_QE) begin
      qe_r <= e_prod[E_P_W-1:E_SHIFT];
    end
    if (state_r == ST_QD) begin
      qd_r <= d_prod[D_P_W-1:D_SHIFT];
    end
    if ((state_r == ST_DUTY) && out_free) begin
      res_duty_r  <= c_sat[DUTY_W-1:0];
      res_below_r <= below_r;
      res_mv_r    <= mv_r;
    end
  end

  assign res.valid          = res_valid_r;
  assign res.duty           = res_duty_r;
  assign res.below_setpoint = res_below_r;
  assign res.measured_mv    = res_mv_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) duty_now_r <= DUTY_MAX)
    else $error("duty state out of range");
  assert property (@(posedge clk) disable iff (!rst_n) start |-> (state_r == ST_IDLE))
    else $error("control update started while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_below_r == (res_mv_r <= $past(cfg.setpoint_mv, 2))) ||
                    $past(state_r) != ST_DUTY)
    else $error("indicator disagrees with measured voltage");
`endif

endmodule

/* sv/buck_duty_regulator_trimmed_mean_top.sv */
// ----------------------------------------------------------------------------
// Buck duty regulator with trimmed-mean sense filter
// A store word (action 0) writes one sample into the 8-entry ring and gives no
// result. A control tick (action 1) runs four scans of the window through one
// shared compare unit (two largest, two smallest), then scaling, error terms
// and duty update, and then moves the result word into the output register.
// The duty update holds while a previous result word still sits stalled in the
// output register. in_stall stays high while a tick is in flight; the next word
// is accepted once the result sits in the output register, even if the
// downstream side is still stalling it.
// ----------------------------------------------------------------------------
module buck_duty_regulator_trimmed_mean_top #(
  parameter int SAMPLE_BITS = bdr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdr_pkg::DUTY_W-1:0]    out_duty,
  output logic                          out_below_setpoint,
  output logic [bdr_pkg::MV_W-1:0]      out_measured_mv,
  input  logic                          cfg_we,
  input  logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdr_pkg::CFG_W-1:0]     cfg_data
);
  import bdr_pkg::*;

  cfg_t                   cfg_r;
  logic                   busy_r;
  logic                   out_valid_r;
  logic [DUTY_W-1:0]      out_duty_r;
  logic                   out_below_r;
  logic [MV_W-1:0]        out_mv_r;

  logic                   in_accept;
  logic                   tick_start;
  logic                   store_en;
  logic                   trim_done;
  logic [SAMPLE_BITS+1:0] mid_sum;
  logic                   out_free;
  res_t                   res;

  assign in_accept  = in_valid && !busy_r;
  assign tick_start = in_accept && in_action;
  assign store_en   = in_accept && !in_action;
  assign out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_mv  <= SETPOINT_RST;
      cfg_r.trip_mv      <= TRIP_RST;
      cfg_r.duty_floor   <= DUTY_FLOOR_RST;
      cfg_r.duty_ceiling <= DUTY_CEILING_RST;
      cfg_r.duty_trip    <= DUTY_TRIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:     cfg_r.setpoint_mv  <= cfg_data[MV_W-1:0];
        REG_TRIP:         cfg_r.trip_mv      <= cfg_data[MV_W-1:0];
        REG_DUTY_FLOOR:   cfg_r.duty_floor   <= cfg_data[DUTY_W-1:0];
        REG_DUTY_CEILING: cfg_r.duty_ceiling <= cfg_data[DUTY_W-1:0];
        REG_DUTY_TRIP:    cfg_r.duty_trip    <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick_start) begin
        busy_r <= 1'b1;
      end else if (res.valid) begin
        busy_r <= 1'b0;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_duty_r  <= res.duty;
      out_below_r <= res.below_setpoint;
      out_mv_r    <= res.measured_mv;
    end
  end

  bdr_trim #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_trim (
    .clk          (clk),
    .rst_n        (rst_n),
    .store_en     (store_en),
    .store_sample (in_sample),
    .start        (tick_start),
    .done         (trim_done),
    .mid_sum      (mid_sum)
  );

  bdr_law #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_law (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (trim_done),
    .mid_sum  (mid_sum),
    .cfg      (cfg_r),
    .out_free (out_free),
    .res      (res)
  );

  assign in_stall           = busy_r;
  assign out_valid          = out_valid_r;
  assign out_duty           = out_duty_r;
  assign out_below_setpoint = out_below_r;
  assign out_measured_mv    = out_mv_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action) |=> in_stall)
    else $error("tick accepted without blocking the input");
  assert property (@(posedge clk) disable iff (!rst_n) res.valid |-> busy_r)
    else $error("result word without a tick in flight");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (out_duty <= DUTY_MAX))
    else $error("duty word out of range");
`endif

endmodule
